/* rtl/core/gce_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and float32 arithmetic steps for the grouped convolution engine.
package gce_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_LOAD_ACT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_WGT  = 2'd1;
  localparam logic [1:0] REQ_LOAD_BIAS = 2'd2;
  localparam logic [1:0] REQ_FETCH     = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_IN_HEIGHT  = 3'd0;
  localparam logic [2:0] CFG_IN_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_PAD_TOP    = 3'd2;
  localparam logic [2:0] CFG_PAD_LEFT   = 3'd3;
  localparam logic [2:0] CFG_OUT_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_OUT_WIDTH  = 3'd5;
  localparam logic [2:0] CFG_STRIDE     = 3'd6;
  localparam logic [2:0] CFG_DILATION   = 3'd7;

  localparam int LOAD_SPAN    = 16384;
  localparam int CURSOR_LIMIT = 32;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  // Command moved from the front queue to the back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] index;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // Multiplier state after the mantissa product
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] k;
    logic [47:0]        p;
  } mul_a_t;

  // Adder state after alignment and add/subtract
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        zsign;
    logic [7:0]  e;
    logic [27:0] s;
  } add_a_t;

  // Output size clamp: zero acts as one, above the cursor range acts as the limit
  function automatic logic [5:0] eff_dim(logic [5:0] d);
    if (d == 6'd0) return 6'd1;
    if (32'(d) > CURSOR_LIMIT) return 6'(CURSOR_LIMIT);
    return d;
  endfunction

  function automatic logic [5:0] clz48(logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] clz27(logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack; a carry out of the mantissa bumps the exponent
  function automatic logic [31:0] round_pack(logic sign, logic [7:0] e, logic [23:0] mant,
                                             logic g, logic st);
    logic [30:0] t;
    logic        inc;
    inc = g & (st | mant[0]);
    t = {e, mant[22:0]} + 31'(inc);
    return {sign, t};
  endfunction

  // Multiply, step one: specials, exponent sum, 24x24 mantissa product
  function automatic mul_a_t fmul_unpack(logic [31:0] a, logic [31:0] b);
    mul_a_t     r;
    logic [7:0] ea, eb, eae, ebe;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    ea = a[30:23];
    eb = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;
    r.sign = a[31] ^ b[31];
    r.spec = 1'b1;
    r.spec_val = 32'd0;
    if (a_nan) r.spec_val = a | QUIET_BIT;
    else if (b_nan) r.spec_val = b | QUIET_BIT;
    else if ((a_inf && b_zero) || (b_inf && a_zero)) r.spec_val = QNAN_DEFAULT;
    else if (a_inf || b_inf) r.spec_val = {r.sign, 8'hFF, 23'd0};
    else r.spec = 1'b0;
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    ma = {ea != 8'd0, a[22:0]};
    mb = {eb != 8'd0, b[22:0]};
    r.k = $signed(11'(eae) + 11'(ebe) - 11'd127);
    r.p = 48'(ma * mb);
    return r;
  endfunction

  // Multiply, step three: normalize by the leading zero count, handle subnormals, round
  function automatic logic [31:0] fmul_round(mul_a_t m, logic [5:0] lz);
    logic signed [10:0] epre;
    logic [10:0]        sh;
    logic [47:0]        q;
    logic [7:0]         e;
    logic               lost;
    if (m.spec) return m.spec_val;
    if (m.p == 48'd0) return {m.sign, 31'd0};
    epre = m.k + 11'sd1 - $signed({5'd0, lz});
    if (epre >= 11'sd255) return {m.sign, 8'hFF, 23'd0};
    lost = 1'b0;
    if (epre >= 11'sd1) begin
      q = m.p << lz;
      e = epre[7:0];
    end else if (m.k >= 11'sd0) begin
      q = m.p << m.k[5:0];
      e = 8'd0;
    end else begin
      sh = 11'(-m.k);
      e = 8'd0;
      if (sh >= 11'd48) begin
        q = 48'd0;
        lost = |m.p;
      end else begin
        q = m.p >> sh[5:0];
        lost = |(m.p & ~(48'hFFFF_FFFF_FFFF << sh[5:0]));
      end
    end
    return round_pack(m.sign, e, q[47:24], q[23], (|q[22:0]) | lost);
  endfunction

  // Add, step one: specials, magnitude swap, alignment with sticky, add or subtract
  function automatic add_a_t fadd_align(logic [31:0] a, logic [31:0] b);
    add_a_t      r;
    logic [31:0] big, sml;
    logic [7:0]  ex, ey, d;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [26:0] yf, ys;
    logic [27:0] xf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.spec = 1'b1;
    r.spec_val = 32'd0;
    if (a_nan) r.spec_val = a | QUIET_BIT;
    else if (b_nan) r.spec_val = b | QUIET_BIT;
    else if (a_inf && b_inf && (a[31] != b[31])) r.spec_val = QNAN_DEFAULT;
    else if (a_inf) r.spec_val = a;
    else if (b_inf) r.spec_val = b;
    else r.spec = 1'b0;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ex = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    ey = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = ex - ey;
    xf = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b000};
    yf = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      ys = {26'd0, |yf};
    end else begin
      ys = yf >> d[4:0];
      ys[0] = ys[0] | (|(yf & ~(27'h7FF_FFFF << d[4:0])));
    end
    r.s = (big[31] ^ sml[31]) ? xf - {1'b0, ys} : xf + {1'b0, ys};
    r.sign = big[31];
    r.zsign = a[31] & b[31];
    r.e = ex;
    return r;
  endfunction

  // Add, step three: normalize, handle subnormals, round
  function automatic logic [31:0] fadd_round(add_a_t x, logic [4:0] lz);
    logic [26:0]       q;
    logic [8:0]        e9;
    logic signed [9:0] epre;
    logic [7:0]        e;
    logic [7:0]        sl;
    if (x.spec) return x.spec_val;
    if (x.s == 28'd0) return {x.zsign, 31'd0};
    if (x.s[27]) begin
      e9 = {1'b0, x.e} + 9'd1;
      if (e9 >= 9'd255) return {x.sign, 8'hFF, 23'd0};
      q = x.s[27:1];
      q[0] = q[0] | x.s[0];
      e = e9[7:0];
    end else begin
      epre = $signed({2'b0, x.e}) - $signed({5'd0, lz});
      if (epre >= 10'sd1) begin
        q = x.s[26:0] << lz;
        e = epre[7:0];
      end else begin
        sl = x.e - 8'd1;
        q = x.s[26:0] << sl[4:0];
        e = 8'd0;
      end
    end
    return round_pack(x.sign, e, q[26:3], q[2], |q[1:0]);
  endfunction

endpackage

/* rtl/core/gce_ifs.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces of the convolution engine.
interface gce_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [13:0] index;
  logic [31:0] load_value;
  modport source(output valid, req_type, index, load_value, input ready);
  modport sink(input valid, req_type, index, load_value, output ready);
endinterface

interface gce_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [3:0]  out_channel;
  logic [4:0]  out_row;
  logic [4:0]  out_col;
  logic        last;
  modport source(output valid, result_value, out_channel, out_row, out_col, last, input ready);
  modport sink(input valid, result_value, out_channel, out_row, out_col, last, output ready);
endinterface

/* rtl/core/grouped_conv2d_engine_top.sv */
`timescale 1ns / 1ps
// Top level of the grouped float32 2-D convolution engine.
//
//  channel  dir  handshake         payload
//  req      in   valid/ready       req_type, index, load_value
//  res      out  valid/ready       result_value, out_channel, out_row, out_col, last
//  cfg      in   cfg_we            cfg_index, cfg_data
//
// A load is written into its store as it leaves the queue head; that happens only in idle.
// A fetch runs its taps one after another (TAPS = IN_CHANNELS/GROUPS*KERNEL_H*KERNEL_W, 144 at
// defaults): each tap runs position, address, store read, a three-step multiply and a three-step
// add in turn, since every add waits on the running sum; a last add then brings in the bias.
// Reset (rst, synchronous) clears the cursor, the queue and the output valid; stores are
// undefined until loaded. The two-entry queue keeps taking beats until it is full, also while
// the back end works or while a result waits to be taken.
module grouped_conv2d_engine_top #(
  parameter int IN_CHANNELS  = 16,
  parameter int OUT_CHANNELS = 16,
  parameter int KERNEL_H     = 3,
  parameter int KERNEL_W     = 3,
  parameter int GROUPS       = 1,
  parameter int MAX_DIM      = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  gce_req_if.sink    req,
  gce_res_if.source  res
);

  gce_pkg::qhead_t head;
  logic            head_pop;

  gce_front #(
    .ACT_DEPTH (IN_CHANNELS * MAX_DIM * MAX_DIM),
    .WGT_DEPTH (OUT_CHANNELS * (IN_CHANNELS / GROUPS) * KERNEL_H * KERNEL_W),
    .BIAS_DEPTH(OUT_CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .head    (head),
    .head_pop(head_pop)
  );

  gce_back #(
    .IN_CHANNELS (IN_CHANNELS),
    .OUT_CHANNELS(OUT_CHANNELS),
    .KERNEL_H    (KERNEL_H),
    .KERNEL_W    (KERNEL_W),
    .GROUPS      (GROUPS),
    .MAX_DIM     (MAX_DIM)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .head     (head),
    .head_pop (head_pop),
    .res      (res)
  );

endmodule

/* rtl/core/gce_front.sv */
`timescale 1ns / 1ps
// Front end: takes request beats, drops loads beyond their store, queues the rest.
module gce_front #(
  parameter int ACT_DEPTH  = 16384,
  parameter int WGT_DEPTH  = 2304,
  parameter int BIAS_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  gce_req_if.sink         req,
  output gce_pkg::qhead_t head,
  input  logic            head_pop
);

  gce_pkg::cmd_t q [2];
  logic [1:0]    cnt;
  logic          wp, rp;
  logic          keep, enq;

  // Classify the beat: fetches always go on, loads only inside their store
  always_comb begin
    case (req.req_type)
      gce_pkg::REQ_LOAD_ACT:  keep = 32'(req.index) < ACT_DEPTH;
      gce_pkg::REQ_LOAD_WGT:  keep = 32'(req.index) < WGT_DEPTH;
      gce_pkg::REQ_LOAD_BIAS: keep = 32'(req.index) < BIAS_DEPTH;
      default:                keep = 1'b1;
    endcase
  end

  assign req.ready  = cnt != 2'd2;
  assign enq        = req.valid && req.ready && keep;
  assign head.valid = cnt != 2'd0;
  assign head.cmd   = q[rp];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= '{kind: req.req_type, index: req.index, value: req.load_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (enq) wp <= ~wp;
      if (head_pop) rp <= ~rp;
      cnt <= cnt + 2'(enq) - 2'(head_pop);
    end
  end

endmodule

/* rtl/core/gce_back.sv */
`timescale 1ns / 1ps
// Back end: stores, configuration, output cursor and the tap-serial float MAC sequencer.
module gce_back #(
  parameter int IN_CHANNELS  = 16,
  parameter int OUT_CHANNELS = 16,
  parameter int KERNEL_H     = 3,
  parameter int KERNEL_W     = 3,
  parameter int GROUPS       = 1,
  parameter int MAX_DIM      = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  gce_pkg::qhead_t head,
  output logic            head_pop,
  gce_res_if.source       res
);

  localparam int CIN_G     = IN_CHANNELS / GROUPS;
  localparam int COUT_G    = OUT_CHANNELS / GROUPS;
  localparam int TAPS      = CIN_G * KERNEL_H * KERNEL_W;
  localparam int ACT_DEPTH = IN_CHANNELS * MAX_DIM * MAX_DIM;
  localparam int ACT_MEM   = (ACT_DEPTH < gce_pkg::LOAD_SPAN) ? ACT_DEPTH : gce_pkg::LOAD_SPAN;
  localparam int AMW       = $clog2(ACT_MEM);
  localparam int WGT_DEPTH = OUT_CHANNELS * TAPS;
  localparam int WMEM      = (WGT_DEPTH < gce_pkg::LOAD_SPAN) ? WGT_DEPTH : gce_pkg::LOAD_SPAN;
  localparam int WMW       = (WMEM > 1) ? $clog2(WMEM) : 1;
  localparam int WPW       = $clog2(WGT_DEPTH + 1);
  localparam int COW       = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int CIW       = (CIN_G > 1) ? $clog2(CIN_G) : 1;
  localparam int KRW       = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int KCW       = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;
  localparam logic [3:0] S_ADDR = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_A1   = 4'd7;
  localparam logic [3:0] S_A2   = 4'd8;
  localparam logic [3:0] S_A3   = 4'd9;

  // First input channel of the group that owns an output channel, by boundary compares
  function automatic logic [6:0] group_base(logic [COW-1:0] ch);
    logic [6:0] b;
    b = 7'd0;
    for (int g = 1; g < GROUPS; g++) begin
      if (32'(ch) >= g * COUT_G) b = 7'(g * CIN_G);
    end
    return b;
  endfunction

  // Configuration
  logic [5:0] in_height, in_width, out_height, out_width;
  logic [3:0] pad_top, pad_left;
  logic [7:0] stride_packed, dilation_packed;

  // Stores
  logic [31:0] act_mem  [ACT_MEM];
  logic [31:0] wgt_mem  [WMEM];
  logic [31:0] bias_mem [OUT_CHANNELS];
  logic [31:0] act_q, wgt_q, bias_q;

  // Sequencer
  logic [3:0]      state;
  logic [COW-1:0]  cur_ch, co;
  logic [4:0]      cur_row, cur_col, orow, ocol;
  logic [WPW-1:0]  wptr;
  logic [CIW-1:0]  ci;
  logic [KRW-1:0]  kr;
  logic [KCW-1:0]  kc;
  logic [6:0]      cstart, chan;
  logic [11:0]     plane;
  logic [11:0]     pos_r, pos_c;
  logic [18:0]     act_addr;
  logic            act_zero;
  logic            bias_phase, olast;
  gce_pkg::mul_a_t mreg;
  logic [5:0]      mlz;
  logic [31:0]     prod, acc;
  gce_pkg::add_a_t areg;
  logic [4:0]      alz;

  logic [5:0]  eh, ew, col1, row1;
  logic [6:0]  ch1;
  logic        is_fetch, fetch_go;
  logic        last_tap, r_in, c_in;
  logic [18:0] addr_sum;
  logic [31:0] sum_out;
  logic [11:0] r_next, c_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_height       <= 6'd32;
      in_width        <= 6'd32;
      pad_top         <= 4'd0;
      pad_left        <= 4'd0;
      out_height      <= 6'd30;
      out_width       <= 6'd30;
      stride_packed   <= 8'd17;
      dilation_packed <= 8'd17;
    end else if (cfg_we) begin
      case (cfg_index)
        gce_pkg::CFG_IN_HEIGHT:  in_height       <= cfg_data[5:0];
        gce_pkg::CFG_IN_WIDTH:   in_width        <= cfg_data[5:0];
        gce_pkg::CFG_PAD_TOP:    pad_top         <= cfg_data[3:0];
        gce_pkg::CFG_PAD_LEFT:   pad_left        <= cfg_data[3:0];
        gce_pkg::CFG_OUT_HEIGHT: out_height      <= cfg_data[5:0];
        gce_pkg::CFG_OUT_WIDTH:  out_width       <= cfg_data[5:0];
        gce_pkg::CFG_STRIDE:     stride_packed   <= cfg_data;
        gce_pkg::CFG_DILATION:   dilation_packed <= cfg_data;
        default: ;
      endcase
    end
  end

  // Queue head handling: loads retire while idle, a fetch also waits for a free output register
  assign is_fetch = head.cmd.kind == gce_pkg::REQ_FETCH;
  assign fetch_go = (state == S_IDLE) && head.valid && is_fetch && !res.valid;
  assign head_pop = (state == S_IDLE) && head.valid && (!is_fetch || !res.valid);

  // Stores: one write port from the queue, registered reads
  always_ff @(posedge clk) begin
    if (head_pop && head.cmd.kind == gce_pkg::REQ_LOAD_ACT)
      act_mem[head.cmd.index[AMW-1:0]] <= head.cmd.value;
    act_q <= act_mem[act_addr[AMW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (head_pop && head.cmd.kind == gce_pkg::REQ_LOAD_WGT)
      wgt_mem[head.cmd.index[WMW-1:0]] <= head.cmd.value;
    wgt_q <= wgt_mem[wptr[WMW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (head_pop && head.cmd.kind == gce_pkg::REQ_LOAD_BIAS)
      bias_mem[head.cmd.index[COW-1:0]] <= head.cmd.value;
    bias_q <= bias_mem[co];
  end

  // Cursor step
  assign eh   = gce_pkg::eff_dim(out_height);
  assign ew   = gce_pkg::eff_dim(out_width);
  assign col1 = 6'(cur_col) + 6'd1;
  assign row1 = 6'(cur_row) + 6'd1;
  assign ch1  = 7'(cur_ch) + 7'd1;

  // Tap position and store address
  assign r_next = 12'(12'(orow) * 12'(stride_packed[7:4]))
                  + 12'(12'(kr) * 12'(dilation_packed[7:4])) - 12'(pad_top);
  assign c_next = 12'(12'(ocol) * 12'(stride_packed[3:0]))
                  + 12'(12'(kc) * 12'(dilation_packed[3:0])) - 12'(pad_left);
  assign r_in     = !pos_r[11] && (pos_r < 12'(in_height));
  assign c_in     = !pos_c[11] && (pos_c < 12'(in_width));
  assign addr_sum = 19'(19'(chan) * 19'(plane)) + 19'(19'(pos_r) * 19'(in_width)) + 19'(pos_c);
  assign last_tap = (32'(ci) == CIN_G - 1) && (32'(kr) == KERNEL_H - 1)
                    && (32'(kc) == KERNEL_W - 1);
  assign sum_out  = gce_pkg::fadd_round(areg, alz);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (fetch_go) begin
          co     <= cur_ch;
          orow   <= cur_row;
          ocol   <= cur_col;
          olast  <= (32'(ch1) >= OUT_CHANNELS) && (row1 >= eh) && (col1 >= ew);
          plane  <= 12'(12'(in_height) * 12'(in_width));
          wptr   <= WPW'(32'(cur_ch) * TAPS);
          cstart <= group_base(cur_ch);
          acc    <= 32'd0;
          ci     <= '0;
          kr     <= '0;
          kc     <= '0;
        end
      end
      S_POS: begin
        pos_r <= r_next;
        pos_c <= c_next;
        chan  <= cstart + 7'(ci);
      end
      S_ADDR: begin
        act_addr <= addr_sum;
        act_zero <= !(r_in && c_in) || (32'(addr_sum) >= ACT_MEM);
      end
      S_M1: mreg <= gce_pkg::fmul_unpack(wgt_q, act_zero ? 32'd0 : act_q);
      S_M2: mlz  <= gce_pkg::clz48(mreg.p);
      S_M3: prod <= gce_pkg::fmul_round(mreg, mlz);
      S_A1: areg <= gce_pkg::fadd_align(acc, bias_phase ? bias_q : prod);
      S_A2: alz  <= gce_pkg::clz27(areg.s[26:0]);
      S_A3: begin
        acc <= sum_out;
        if (!bias_phase) begin
          wptr <= wptr + WPW'(1);
          if (32'(kc) < KERNEL_W - 1) begin
            kc <= kc + KCW'(1);
          end else begin
            kc <= '0;
            if (32'(kr) < KERNEL_H - 1) begin
              kr <= kr + KRW'(1);
            end else begin
              kr <= '0;
              ci <= (32'(ci) < CIN_G - 1) ? ci + CIW'(1) : '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control: state, cursor, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_ch     <= '0;
      cur_row    <= 5'd0;
      cur_col    <= 5'd0;
      bias_phase <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (fetch_go) begin
            state      <= S_POS;
            bias_phase <= 1'b0;
            if (col1 < ew) begin
              cur_col <= 5'(col1);
            end else begin
              cur_col <= 5'd0;
              if (row1 < eh) begin
                cur_row <= 5'(row1);
              end else begin
                cur_row <= 5'd0;
                cur_ch  <= (32'(ch1) < OUT_CHANNELS) ? COW'(ch1) : '0;
              end
            end
          end
        end
        S_POS:  state <= S_ADDR;
        S_ADDR: state <= S_RD;
        S_RD:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= S_M3;
        S_M3:   state <= S_A1;
        S_A1:   state <= S_A2;
        S_A2:   state <= S_A3;
        S_A3: begin
          if (bias_phase) begin
            res.valid <= 1'b1;
            state     <= S_IDLE;
          end else if (last_tap) begin
            bias_phase <= 1'b1;
            state      <= S_A1;
          end else begin
            state <= S_POS;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_A3 && bias_phase) begin
      res.result_value <= sum_out;
      res.out_channel  <= 4'(8'(co));
      res.out_row      <= orow;
      res.out_col      <= ocol;
      res.last         <= olast;
    end
  end

  // Checks
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> state == S_IDLE) else $error("queue pop outside idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_A3 && $past(bias_phase))
    else $error("result raised outside bias add");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> (32'(ci) < CIN_G) && (32'(kr) < KERNEL_H) && (32'(kc) < KERNEL_W))
    else $error("tap counter out of range");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    fetch_go |=> !res.valid) else $error("fetch started with result pending");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the grouped float32 convolution engine.
module tb_top;

  localparam int N_CIN   = 16;
  localparam int N_COUT  = 16;
  localparam int KH      = 3;
  localparam int KW      = 3;
  localparam int N_GRP   = 1;
  localparam int CIN_G   = N_CIN / N_GRP;
  localparam int COUT_G  = N_COUT / N_GRP;
  localparam int TAPS    = CIN_G * KH * KW;
  localparam int ACT_N   = N_CIN * 32 * 32;
  localparam int WGT_N   = N_COUT * TAPS;
  localparam int DRAIN   = 9 * TAPS + 200;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  ch;
    logic [4:0]  row;
    logic [4:0]  col;
    logic        last;
  } conv_elem_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] idx;
    logic [31:0] val;
    logic        typed;
    logic [31:0] ev;
    logic [3:0]  ech;
    logic        elast;
  } stim_row_t;

  logic clk;
  logic rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  gce_req_if req_ch();
  gce_res_if res_ch();

  grouped_conv2d_engine_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .res(res_ch)
  );

  // Shadow copy of the engine state
  logic [31:0] act_mem [ACT_N];
  logic [31:0] wgt_mem [WGT_N];
  logic [31:0] bias_mem [N_COUT];
  logic [3:0]  cur_ch;
  logic [4:0]  cur_row, cur_col;
  logic [5:0]  in_h, in_w, out_h, out_w;
  logic [3:0]  pad_t, pad_l;
  logic [7:0]  stride_r, dil_r;

  conv_elem_t  pending_elems[$];
  stim_row_t   dir_rows[$];
  int          errors;
  bit          stall_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------- float32 arithmetic, round to nearest even ----------------
  function automatic logic [31:0] round_to_single(logic sgn, logic [319:0] m, int ex);
    int          p, eu, drop;
    logic [319:0] q, rem;
    logic        half, st;
    logic [63:0] bits;
    if (m == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 320; i++) if (m[i]) p = i;
    eu = p + ex - 23;
    if (eu < -149) eu = -149;
    drop = eu - ex;
    if (drop > 0) begin
      q = m >> drop;
      half = m[drop-1];
      rem = m & ((320'd1 << (drop - 1)) - 320'd1);
      st = (rem != 0);
      if (half && (st || q[0])) q = q + 320'd1;
    end else begin
      q = m << (-drop);
    end
    bits = (64'(eu + 149) << 23) + q[63:0];
    if (bits >= 64'h7F80_0000) return {sgn, 8'hFF, 23'd0};
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] x);
    return {x[30:23] != 8'd0, x[22:0]};
  endfunction

  function automatic int unit_exp(logic [31:0] x);
    return ((x[30:23] == 8'd0) ? 1 : int'(x[30:23])) - 150;
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [47:0] pr;
    sgn = a[31] ^ b[31];
    if (is_nan(a)) return a | gce_pkg::QUIET_BIT;
    if (is_nan(b)) return b | gce_pkg::QUIET_BIT;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
      return gce_pkg::QNAN_DEFAULT;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
    pr = 48'(sig_of(a)) * 48'(sig_of(b));
    return round_to_single(sgn, 320'(pr), unit_exp(a) + unit_exp(b));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    int           ua, ub, mn;
    logic [319:0] ma, mb, m;
    logic         sgn;
    if (is_nan(a)) return a | gce_pkg::QUIET_BIT;
    if (is_nan(b)) return b | gce_pkg::QUIET_BIT;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return gce_pkg::QNAN_DEFAULT;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    ua = unit_exp(a);
    ub = unit_exp(b);
    mn = (ua < ub) ? ua : ub;
    ma = 320'(sig_of(a)) << (ua - mn);
    mb = 320'(sig_of(b)) << (ub - mn);
    if (a[31] == b[31]) begin
      m = ma + mb;
      sgn = a[31];
    end else if (ma >= mb) begin
      m = ma - mb;
      sgn = a[31];
    end else begin
      m = mb - ma;
      sgn = b[31];
    end
    if (m == 0) return {a[31] & b[31], 31'd0};
    return round_to_single(sgn, m, mn);
  endfunction

  // ---------------- convolution predictor ----------------
  function automatic int clamp_dim(logic [5:0] d);
    if (d == 0) return 1;
    if (d > 32) return 32;
    return int'(d);
  endfunction

  function automatic logic [31:0] pixel_at(int c, int r, int cc);
    int addr;
    if (r < 0 || cc < 0 || r >= int'(in_h) || cc >= int'(in_w)) return 32'd0;
    addr = c * int'(in_h) * int'(in_w) + r * int'(in_w) + cc;
    if (addr >= ACT_N) return 32'd0;
    return act_mem[addr];
  endfunction

  function automatic logic [31:0] conv_point(int co, int orow, int ocol);
    int          sh, sw, dh, dw, cstart, wbase, r, cc;
    logic [31:0] acc;
    sh = int'(stride_r[7:4]);
    sw = int'(stride_r[3:0]);
    dh = int'(dil_r[7:4]);
    dw = int'(dil_r[3:0]);
    cstart = (co / COUT_G) * CIN_G;
    wbase = co * TAPS;
    acc = 32'd0;
    for (int ci = 0; ci < CIN_G; ci++)
      for (int kr = 0; kr < KH; kr++) begin
        r = orow * sh + kr * dh - int'(pad_t);
        for (int kc = 0; kc < KW; kc++) begin
          cc = ocol * sw + kc * dw - int'(pad_l);
          acc = f32_add(acc, f32_mul(wgt_mem[wbase + (ci * KH + kr) * KW + kc],
                                     pixel_at(cstart + ci, r, cc)));
        end
      end
    return f32_add(acc, bias_mem[co]);
  endfunction

  // Element under the cursor, then step the cursor
  function automatic conv_elem_t next_output_element();
    conv_elem_t e;
    int eh, ew;
    eh = clamp_dim(out_h);
    ew = clamp_dim(out_w);
    e.value = conv_point(int'(cur_ch), int'(cur_row), int'(cur_col));
    e.ch = cur_ch;
    e.row = cur_row;
    e.col = cur_col;
    e.last = (int'(cur_ch) + 1 >= N_COUT) && (int'(cur_row) + 1 >= eh) &&
             (int'(cur_col) + 1 >= ew);
    if (int'(cur_col) + 1 < ew) cur_col = cur_col + 5'd1;
    else begin
      cur_col = 5'd0;
      if (int'(cur_row) + 1 < eh) cur_row = cur_row + 5'd1;
      else begin
        cur_row = 5'd0;
        cur_ch = (int'(cur_ch) + 1 < N_COUT) ? cur_ch + 4'd1 : 4'd0;
      end
    end
    return e;
  endfunction

  // Update shadow state for one accepted beat; a fetch queues its element
  task automatic apply_request(input logic [1:0] kind, input logic [13:0] idx,
                               input logic [31:0] val);
    case (kind)
      gce_pkg::REQ_LOAD_ACT: if (int'(idx) < ACT_N) act_mem[idx] = val;
      gce_pkg::REQ_LOAD_WGT: if (int'(idx) < WGT_N) wgt_mem[idx] = val;
      gce_pkg::REQ_LOAD_BIAS: if (int'(idx) < N_COUT) bias_mem[idx] = val;
      default: pending_elems.push_back(next_output_element());
    endcase
  endtask

  // ---------------- drivers ----------------
  task automatic send_beat(input logic [1:0] kind, input logic [13:0] idx,
                           input logic [31:0] val);
    while (stall_on && $urandom_range(99) < 22) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.index <= idx;
    req_ch.load_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Write all eight registers; the block must be idle
  task automatic write_regs(input logic [7:0] ih, input logic [7:0] iw, input logic [7:0] pt,
                            input logic [7:0] pl, input logic [7:0] oh, input logic [7:0] ow,
                            input logic [7:0] st, input logic [7:0] dl);
    logic [7:0] vals [8];
    vals = '{ih, iw, pt, pl, oh, ow, st, dl};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    in_h = ih[5:0];
    in_w = iw[5:0];
    pad_t = pt[3:0];
    pad_l = pl[3:0];
    out_h = oh[5:0];
    out_w = ow[5:0];
    stride_r = st;
    dil_r = dl;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] tame_float();
    return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] any_float();
    return ($urandom_range(99) < 85) ? tame_float() : 32'($urandom);
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [13:0] idx, input logic [31:0] val,
                         input logic typed, input logic [31:0] ev, input logic [3:0] ech,
                         input logic elast);
    dir_rows.push_back({kind, idx, val, typed, ev, ech, elast});
  endtask

  // ---------------- result monitor ----------------
  initial begin
    conv_elem_t e;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (pending_elems.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat value %h", res_ch.result_value));
        end else begin
          e = pending_elems.pop_front();
          if (res_ch.result_value !== e.value || res_ch.out_channel !== e.ch ||
              res_ch.out_row !== e.row || res_ch.out_col !== e.col || res_ch.last !== e.last)
            report_mismatch($sformatf(
              "got %h ch%0d r%0d c%0d l%0b, want %h ch%0d r%0d c%0d l%0b",
              res_ch.result_value, res_ch.out_channel, res_ch.out_row, res_ch.out_col,
              res_ch.last, e.value, e.ch, e.row, e.col, e.last));
        end
      end
      if (rst) res_ch.ready <= 1'b0;
      else res_ch.ready <= !(stall_on && $urandom_range(99) < 22);
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    logic [7:0]  phase_cfg [6][8];
    int          k;
    logic [1:0]  kind;
    logic [13:0] idx;
    logic [31:0] val;
    conv_elem_t  e;
    stim_row_t   sr;

    errors = 0;
    stall_on = 1'b1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= gce_pkg::CFG_IN_HEIGHT;
    cfg_data <= 8'd0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= gce_pkg::REQ_LOAD_ACT;
    req_ch.index <= 14'd0;
    req_ch.load_value <= 32'd0;
    cur_ch = 0;
    cur_row = 0;
    cur_col = 0;
    in_h = 32;
    in_w = 32;
    pad_t = 0;
    pad_l = 0;
    out_h = 30;
    out_w = 30;
    stride_r = 8'h11;
    dil_r = 8'h11;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty input image, 1x1 output: each element is the bias plus products with zero pixels
    write_regs(8'd0, 8'd63, 8'd15, 8'd15, 8'd1, 8'd1, 8'hFF, 8'h00);

    // Fill every store so that no unwritten entry is ever read
    for (int i = 0; i < ACT_N; i++) begin
      val = tame_float();
      send_beat(gce_pkg::REQ_LOAD_ACT, 14'(i), val);
      apply_request(gce_pkg::REQ_LOAD_ACT, 14'(i), val);
    end
    for (int i = 0; i < WGT_N; i++) begin
      val = tame_float();
      send_beat(gce_pkg::REQ_LOAD_WGT, 14'(i), val);
      apply_request(gce_pkg::REQ_LOAD_WGT, 14'(i), val);
    end
    for (int i = 0; i < N_COUT; i++) begin
      val = tame_float();
      send_beat(gce_pkg::REQ_LOAD_BIAS, 14'(i), val);
      apply_request(gce_pkg::REQ_LOAD_BIAS, 14'(i), val);
    end

    // Directed table: bias passthrough, NaN and infinity, signed zero, ignored loads
    add_row(gce_pkg::REQ_LOAD_BIAS, 14'd0, 32'h3F80_0000, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'h3FFF, 32'hFFFF_FFFF, 1, 32'h3F80_0000, 4'd0, 0);
    add_row(gce_pkg::REQ_LOAD_BIAS, 14'd1, 32'h7F80_0001, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'd0, 32'd0, 1, 32'h7FC0_0001, 4'd1, 0);
    add_row(gce_pkg::REQ_LOAD_BIAS, 14'd2, 32'hFF80_0000, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'd0, 32'd0, 1, 32'hFF80_0000, 4'd2, 0);
    add_row(gce_pkg::REQ_LOAD_BIAS, 14'd3, 32'h8000_0000, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'd0, 32'd0, 1, 32'h0000_0000, 4'd3, 0);
    add_row(gce_pkg::REQ_LOAD_WGT, 14'd576, 32'h7F80_0000, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'd0, 32'd0, 1, gce_pkg::QNAN_DEFAULT, 4'd4, 0);
    add_row(gce_pkg::REQ_LOAD_BIAS, 14'h3FFF, 32'h1234_5678, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_LOAD_WGT, 14'h3FFF, 32'h1234_5678, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_LOAD_WGT, 14'd2303, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_LOAD_ACT, 14'd0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(gce_pkg::REQ_LOAD_ACT, 14'h3FFF, 32'h0000_0000, 0, 0, 0, 0);
    for (int i = 5; i < 15; i++) add_row(gce_pkg::REQ_FETCH, 14'(i), 32'(i), 0, 0, 0, 0);
    add_row(gce_pkg::REQ_FETCH, 14'd0, 32'd0, 1, 32'hFFFF_FFFF, 4'd15, 1);

    foreach (dir_rows[i]) begin
      sr = dir_rows[i];
      send_beat(sr.kind, sr.idx, sr.val);
      if (sr.typed) begin
        e = next_output_element();
        e.value = sr.ev;
        e.ch = sr.ech;
        e.row = 5'd0;
        e.col = 5'd0;
        e.last = sr.elast;
        pending_elems.push_back(e);
      end else begin
        apply_request(sr.kind, sr.idx, sr.val);
      end
    end
    wait_drained();

    // Random phases: in_h, in_w, pad_t, pad_l, out_h, out_w, stride, dilation
    phase_cfg[0] = '{8'd32, 8'd32, 8'd0, 8'd0, 8'd30, 8'd30, 8'h11, 8'h11};
    phase_cfg[1] = '{8'd8, 8'd8, 8'd1, 8'd1, 8'd8, 8'd8, 8'h11, 8'h11};
    phase_cfg[2] = '{8'd32, 8'd32, 8'd15, 8'd15, 8'd32, 8'd32, 8'hFF, 8'hFF};
    phase_cfg[3] = '{8'd63, 8'd63, 8'd2, 8'd3, 8'd0, 8'd63, 8'h00, 8'h00};
    phase_cfg[4] = '{8'd1, 8'd1, 8'd0, 8'd0, 8'd4, 8'd5, 8'h21, 8'h12};
    phase_cfg[5] = '{8'd16, 8'd20, 8'd3, 8'd0, 8'd10, 8'd7, 8'h32, 8'h23};

    for (int ph = 0; ph < 6; ph++) begin
      write_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3],
                 phase_cfg[ph][4], phase_cfg[ph][5], phase_cfg[ph][6], phase_cfg[ph][7]);
      // first phase runs with no idling on either side
      stall_on = (ph != 0);
      if (ph == 0) begin
        // undo the poisoned entries from the directed table
        val = tame_float();
        send_beat(gce_pkg::REQ_LOAD_ACT, 14'd0, val);
        apply_request(gce_pkg::REQ_LOAD_ACT, 14'd0, val);
        val = tame_float();
        send_beat(gce_pkg::REQ_LOAD_WGT, 14'd576, val);
        apply_request(gce_pkg::REQ_LOAD_WGT, 14'd576, val);
        val = tame_float();
        send_beat(gce_pkg::REQ_LOAD_WGT, 14'd2303, val);
        apply_request(gce_pkg::REQ_LOAD_WGT, 14'd2303, val);
      end
      for (int n = 0; n < 170; n++) begin
        // hold off until every element so far has come back
        if (ph == 2 && n == 80) begin
          req_ch.valid <= 1'b0;
          while (pending_elems.size() != 0) @(posedge clk);
        end
        k = $urandom_range(99);
        idx = 14'($urandom);
        val = any_float();
        if (k < 15) begin
          kind = gce_pkg::REQ_FETCH;
          val = 32'($urandom);
        end else if (k < 55) begin
          kind = gce_pkg::REQ_LOAD_ACT;
        end else if (k < 85) begin
          kind = gce_pkg::REQ_LOAD_WGT;
          if ($urandom_range(99) < 90) idx = 14'($urandom_range(WGT_N - 1));
        end else begin
          kind = gce_pkg::REQ_LOAD_BIAS;
          if ($urandom_range(99) < 80) idx = 14'($urandom_range(N_COUT - 1));
        end
        send_beat(kind, idx, val);
        apply_request(kind, idx, val);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
